### rtl/core/rscdp_pkg.sv
// Package for the rotate, scale and clip dot plotter.
// Holds the request and span structs, register indexes, reset values and widths.
// No dependencies.
package rscdp_pkg;

    localparam int DEF_SCREEN_WIDTH  = 640;
    localparam int DEF_SCREEN_HEIGHT = 480;
    localparam int DEF_MAX_DOT       = 33;

    localparam int POS_W   = 20;
    localparam int TRIG_W  = 16;
    localparam int CTR_W   = 20;
    localparam int SCRN_W  = 10;
    localparam int SIZE_W  = 6;
    localparam int HALF_W  = 5;
    localparam int COLOR_W = 8;
    localparam int ADDR_W  = 19;
    localparam int CFG_W   = 20;
    localparam int IDX_W   = 3;

    localparam int PROD_W  = POS_W + TRIG_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int Q_SHIFT = 14;
    localparam int ROT_W   = SUM_W - Q_SHIFT;
    localparam int V_W     = ROT_W + 1;
    localparam int SCR_W   = V_W + 1;
    localparam int CMP_W   = SCR_W + 1;

    localparam logic [IDX_W-1:0] REG_ROT_COS    = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROT_SIN    = 3'd1;
    localparam logic [IDX_W-1:0] REG_CENTER_X   = 3'd2;
    localparam logic [IDX_W-1:0] REG_CENTER_Y   = 3'd3;
    localparam logic [IDX_W-1:0] REG_OFFSET_X   = 3'd4;
    localparam logic [IDX_W-1:0] REG_OFFSET_Y   = 3'd5;
    localparam logic [IDX_W-1:0] REG_CLIP_LEFT  = 3'd6;
    localparam logic [IDX_W-1:0] REG_CLIP_RIGHT = 3'd7;

    localparam logic signed [TRIG_W-1:0] RST_ROT_COS    = 16'sd16384;
    localparam logic signed [TRIG_W-1:0] RST_ROT_SIN    = 16'sd0;
    localparam logic signed [CTR_W-1:0]  RST_CENTER     = 20'sd0;
    localparam logic [SCRN_W-1:0]        RST_OFFSET     = 10'd96;
    localparam logic [SCRN_W-1:0]        RST_CLIP_LEFT  = 10'd0;
    localparam logic [SCRN_W-1:0]        RST_CLIP_RIGHT = 10'd192;

    localparam logic [SUM_W-1:0] Q_BIAS = SUM_W'((1 << Q_SHIFT) - 1);

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [SIZE_W-1:0]       dot_size;
        logic [COLOR_W-1:0]      color;
    } point_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  row_address;
        logic [SIZE_W-1:0]  span_length;
        logic [COLOR_W-1:0] paint_color;
        logic               last_row;
    } span_t;

endpackage

### rtl/core/rotate_scale_clip_dot_plotter_top.sv
// A point's first span reaches m_data through stages 1 to 4 and the span generator.
// A point may enter every cycle while s_ready is high; the span generator emits one
// row per cycle while m_ready is high, so a dot of size n holds the output for n rows
// and sets the point rate. Clipped points emit nothing and do not stall.
// Reset (aresetn low, synchronous) clears all stage valid bits and loads register defaults.
// Depends on rscdp_pkg.
module rotate_scale_clip_dot_plotter_top #(
    parameter int SCREEN_WIDTH  = rscdp_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = rscdp_pkg::DEF_SCREEN_HEIGHT,
    parameter int MAX_DOT       = rscdp_pkg::DEF_MAX_DOT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [rscdp_pkg::IDX_W-1:0] cfg_index,
    input  logic [rscdp_pkg::CFG_W-1:0] cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  rscdp_pkg::point_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output rscdp_pkg::span_t            m_data
);
    import rscdp_pkg::*;

    localparam logic [ADDR_W-1:0]       W_STEP   = ADDR_W'(SCREEN_WIDTH);
    localparam logic signed [CMP_W-1:0] HEIGHT_S = CMP_W'(SCREEN_HEIGHT);
    localparam logic [SIZE_W:0]         MAX_S    = (SIZE_W + 1)'(MAX_DOT);

    logic signed [TRIG_W-1:0] rot_cos_reg, rot_sin_reg;
    logic signed [CTR_W-1:0]  center_x_reg, center_y_reg;
    logic [SCRN_W-1:0]        offset_x_reg, offset_y_reg, clip_left_reg, clip_right_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_cos_reg    <= RST_ROT_COS;
            rot_sin_reg    <= RST_ROT_SIN;
            center_x_reg   <= RST_CENTER;
            center_y_reg   <= RST_CENTER;
            offset_x_reg   <= RST_OFFSET;
            offset_y_reg   <= RST_OFFSET;
            clip_left_reg  <= RST_CLIP_LEFT;
            clip_right_reg <= RST_CLIP_RIGHT;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ROT_COS:    rot_cos_reg    <= cfg_data[TRIG_W-1:0];
                REG_ROT_SIN:    rot_sin_reg    <= cfg_data[TRIG_W-1:0];
                REG_CENTER_X:   center_x_reg   <= cfg_data[CTR_W-1:0];
                REG_CENTER_Y:   center_y_reg   <= cfg_data[CTR_W-1:0];
                REG_OFFSET_X:   offset_x_reg   <= cfg_data[SCRN_W-1:0];
                REG_OFFSET_Y:   offset_y_reg   <= cfg_data[SCRN_W-1:0];
                REG_CLIP_LEFT:  clip_left_reg  <= cfg_data[SCRN_W-1:0];
                REG_CLIP_RIGHT: clip_right_reg <= cfg_data[SCRN_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage registers.
    logic                     s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic signed [PROD_W-1:0] s1_xc_reg, s1_ys_reg, s1_xs_reg, s1_yc_reg;
    logic [SIZE_W-1:0]        s1_size_reg, s2_size_reg, s3_size_reg, s4_size_reg;
    logic [HALF_W-1:0]        s1_hw_reg, s2_hw_reg, s3_hw_reg;
    logic [COLOR_W-1:0]       s1_color_reg, s2_color_reg, s3_color_reg, s4_color_reg;
    logic signed [V_W-1:0]    s2_vx_reg, s2_vy_reg;
    logic signed [SCR_W-1:0]  s3_sx_reg, s3_sy_reg;
    logic                     s4_pass_reg;
    logic [ADDR_W-1:0]        s4_addr_reg;

    logic                     gen_valid_reg, gen_valid_next;
    logic [ADDR_W-1:0]        gen_addr_reg, gen_addr_next;
    logic [SIZE_W-1:0]        gen_size_reg, gen_size_next;
    logic [SIZE_W-1:0]        gen_row_reg, gen_row_next;
    logic [COLOR_W-1:0]       gen_color_reg, gen_color_next;

    logic gen_last, gen_free, s4_take, s4_ready, s3_ready, s2_ready;

    assign gen_last = (gen_row_reg == gen_size_reg - SIZE_W'(1));
    assign gen_free = !gen_valid_reg || (m_ready && gen_last);
    assign s4_take  = s4_valid_reg && (!s4_pass_reg || gen_free);
    assign s4_ready = !s4_valid_reg || s4_take;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s_ready  = !s1_valid_reg || s2_ready;

    // Stage 1: size clamp and the four rotation products.
    logic [SIZE_W-1:0] in_size;

    always_comb begin
        if (s_data.dot_size == '0) begin
            in_size = SIZE_W'(1);
        end else if ({1'b0, s_data.dot_size} > MAX_S) begin
            in_size = MAX_S[SIZE_W-1:0];
        end else begin
            in_size = s_data.dot_size;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            s1_xc_reg    <= PROD_W'(s_data.pos_x) * PROD_W'(rot_cos_reg);
            s1_ys_reg    <= PROD_W'(s_data.pos_y) * PROD_W'(rot_sin_reg);
            s1_xs_reg    <= PROD_W'(s_data.pos_x) * PROD_W'(rot_sin_reg);
            s1_yc_reg    <= PROD_W'(s_data.pos_y) * PROD_W'(rot_cos_reg);
            s1_size_reg  <= in_size;
            s1_hw_reg    <= in_size[SIZE_W-1:1];
            s1_color_reg <= s_data.color;
        end
    end

    // Stage 2: sums, division by 2^14 toward zero, center subtraction.
    logic signed [SUM_W-1:0] sum_x, sum_y, bias_x, bias_y;
    logic signed [ROT_W-1:0] rot_x, rot_y;

    always_comb begin
        sum_x  = SUM_W'(s1_xc_reg) - SUM_W'(s1_ys_reg);
        sum_y  = SUM_W'(s1_xs_reg) + SUM_W'(s1_yc_reg);
        bias_x = sum_x + (sum_x[SUM_W-1] ? $signed(Q_BIAS) : $signed(SUM_W'(0)));
        bias_y = sum_y + (sum_y[SUM_W-1] ? $signed(Q_BIAS) : $signed(SUM_W'(0)));
        rot_x  = bias_x[SUM_W-1:Q_SHIFT];
        rot_y  = bias_y[SUM_W-1:Q_SHIFT];
    end

    always_ff @(posedge aclk) begin
        if (s2_ready) begin
            s2_vx_reg    <= V_W'(rot_x) - V_W'(center_x_reg);
            s2_vy_reg    <= V_W'(rot_y) - V_W'(center_y_reg);
            s2_size_reg  <= s1_size_reg;
            s2_hw_reg    <= s1_hw_reg;
            s2_color_reg <= s1_color_reg;
        end
    end

    // Stage 3: scale by three quarters with a floor shift, then add the offset.
    logic signed [V_W-1:0] scl_x, scl_y;

    assign scl_x = s2_vx_reg - (s2_vx_reg >>> 2);
    assign scl_y = s2_vy_reg - (s2_vy_reg >>> 2);

    always_ff @(posedge aclk) begin
        if (s3_ready) begin
            s3_sx_reg    <= SCR_W'(scl_x) + $signed(SCR_W'(offset_x_reg));
            s3_sy_reg    <= SCR_W'(scl_y) + $signed(SCR_W'(offset_y_reg));
            s3_size_reg  <= s2_size_reg;
            s3_hw_reg    <= s2_hw_reg;
            s3_color_reg <= s2_color_reg;
        end
    end

    // Stage 4: clipping and the address of the top row.
    logic signed [CMP_W-1:0] sx_c, sy_c, hw_c, lo_x, hi_x, col_c, row_c;
    logic                    pass;

    always_comb begin
        sx_c  = CMP_W'(s3_sx_reg);
        sy_c  = CMP_W'(s3_sy_reg);
        hw_c  = $signed(CMP_W'(s3_hw_reg));
        lo_x  = $signed(CMP_W'(clip_left_reg)) + hw_c;
        hi_x  = $signed(CMP_W'(clip_right_reg)) - hw_c;
        col_c = sx_c - hw_c;
        row_c = sy_c - hw_c;
        pass  = (sx_c >= lo_x) && (sx_c < hi_x) && (sy_c >= hw_c) && (sy_c < HEIGHT_S - hw_c);
    end

    always_ff @(posedge aclk) begin
        if (s4_ready) begin
            s4_pass_reg  <= pass;
            s4_addr_reg  <= ADDR_W'(row_c) * W_STEP + ADDR_W'(col_c);
            s4_size_reg  <= s3_size_reg;
            s4_color_reg <= s3_color_reg;
        end
    end

    // Span generator, which is also the output register.
    always_comb begin
        gen_valid_next = gen_valid_reg;
        gen_addr_next  = gen_addr_reg;
        gen_size_next  = gen_size_reg;
        gen_row_next   = gen_row_reg;
        gen_color_next = gen_color_reg;
        if (gen_free) begin
            gen_valid_next = s4_valid_reg && s4_pass_reg;
            gen_addr_next  = s4_addr_reg;
            gen_size_next  = s4_size_reg;
            gen_row_next   = '0;
            gen_color_next = s4_color_reg;
        end else if (m_ready) begin
            gen_addr_next = gen_addr_reg + W_STEP;
            gen_row_next  = gen_row_reg + SIZE_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        gen_addr_reg  <= gen_addr_next;
        gen_size_reg  <= gen_size_next;
        gen_row_reg   <= gen_row_next;
        gen_color_reg <= gen_color_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            gen_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready) begin
                s4_valid_reg <= s3_valid_reg;
            end
            gen_valid_reg <= gen_valid_next;
        end
    end

    assign m_valid             = gen_valid_reg;
    assign m_data.row_address  = gen_addr_reg;
    assign m_data.span_length  = gen_size_reg;
    assign m_data.paint_color  = gen_color_reg;
    assign m_data.last_row     = gen_last;

`ifndef SYNTHESIS
    a_rows_not_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !gen_last) |=> m_valid)
        else $error("dot ended before its last row");

    a_row_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !gen_last) |=>
            (m_data.row_address == $past(m_data.row_address) + W_STEP))
        else $error("row address did not advance by one screen line");

    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (gen_row_reg < gen_size_reg && gen_size_reg != '0))
        else $error("row counter outside the dot");

    a_clipped_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (s4_valid_reg && !s4_pass_reg) |-> s4_take)
        else $error("clipped point stalled the pipeline");
`endif

endmodule
